[hw/rtl/dtr_pkg.sv]
// Shared types and constants for the timed de-duplication record table.
// Holds the item payload structs, the stored record layout and the operation codes.
// No dependencies.
package dtr_pkg;

  // Operation codes carried in the func field of an input item.
  localparam logic [1:0] FUNC_CHECK  = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  // Expiry limit after reset, in milliseconds.
  localparam logic [31:0] EXPIRY_RESET = 32'd6000;

  // One input item.
  typedef struct packed {
    logic [1:0]         func;
    logic [31:0]        now_ms;
    logic signed [31:0] seed;
    logic [15:0]        create_info;
    logic [15:0]        item_index;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic       hit;
    logic       stored;
    logic [7:0] occupancy;
  } out_item_t;

  // One stored record, as held in the record memory.
  typedef struct packed {
    logic [31:0] stamp;
    logic [31:0] seed;
    logic [15:0] create_info;
    logic [15:0] item_index;
  } record_t;

endpackage

[hw/rtl/dtr_mem.sv]
// Record memory of the de-duplication table: one write port, two read ports.
// Read data is registered, with write-through forwarding for a same-address access.
// Depends on dtr_pkg for the record layout.
module dtr_mem #(
  parameter int Depth = 128,
  parameter int AddrW = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  dtr_pkg::record_t     wdata_i,
  input  logic [AddrW-1:0]     raddr_a_i,
  input  logic [AddrW-1:0]     raddr_b_i,
  output dtr_pkg::record_t     rdata_a_o,
  output dtr_pkg::record_t     rdata_b_o
);

  dtr_pkg::record_t mem_q [Depth];
  dtr_pkg::record_t rd_a_q;
  dtr_pkg::record_t rd_b_q;
  dtr_pkg::record_t wdata_q;
  logic             fwd_a_q;
  logic             fwd_b_q;

  // Storage array: one write and two reads per cycle. A read that meets a write
  // to the same entry returns the old contents, which the bypass below replaces.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_a_q  <= mem_q[raddr_a_i];
    rd_b_q  <= mem_q[raddr_b_i];
    wdata_q <= wdata_i;
  end

  // Remember which read port collided with the write in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_a_q <= 1'b0;
      fwd_b_q <= 1'b0;
    end else begin
      fwd_a_q <= we_i && (waddr_i == raddr_a_i);
      fwd_b_q <= we_i && (waddr_i == raddr_b_i);
    end
  end

  // Write-through bypass so a read always sees the newest data.
  assign rdata_a_o = fwd_a_q ? wdata_q : rd_a_q;
  assign rdata_b_o = fwd_b_q ? wdata_q : rd_b_q;

endmodule

[hw/rtl/timed_dedup_record_table_unit.sv]
// Top level of the timed de-duplication record table.
// Holds the control sequencer, the record count and the expiry register.
// Depends on dtr_pkg and dtr_mem.

// The table keeps up to CAPACITY records in a two-read-port memory and handles
// one item at a time. An insert, an unused operation code, or a check or remove
// on an empty table finishes on acceptance; any other check or remove walks the
// held records. The walk examines one record per cycle, reading the current and
// the last slot together, and a dropped record is replaced by the last one in the
// same cycle. Every examination either drops a record or moves the pointer on,
// so a walk never examines more slots than records held. A finished result goes
// to the output register if it is free, else waits in res_q while input stalls.
// From the output register it can wait while the next item is accepted.
module timed_dedup_record_table_unit #(
  parameter int CAPACITY = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dtr_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dtr_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i
);

  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_PUSH
  } state_e;

  state_e             state_q, state_d;
  logic [CntW-1:0]    pos_q, pos_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [31:0]        expiry_q;
  dtr_pkg::in_item_t  req_q;
  dtr_pkg::out_item_t res_q, res_d;
  logic               out_valid_q;
  dtr_pkg::out_item_t out_item_q;

  logic               accept;
  logic               out_free;
  logic               finish;
  logic               hit_d;
  logic               stored_d;
  logic               mem_we;
  logic [AddrW-1:0]   mem_waddr;
  dtr_pkg::record_t   mem_wdata;
  logic [AddrW-1:0]   raddr_a;
  logic [AddrW-1:0]   raddr_b;
  dtr_pkg::record_t   rd_a;
  dtr_pkg::record_t   rd_b;
  dtr_pkg::record_t   new_rec;
  logic [CntW-1:0]    last_idx;
  logic [CntW-1:0]    pos_inc;
  logic [CntW-1:0]    count_dec;
  logic [31:0]        age;
  logic               expired;
  logic               key_match;

  dtr_mem #(
    .Depth (CAPACITY),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // Handshake on both sides.
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Record built from an incoming insert.
  assign new_rec.stamp       = in_item_i.now_ms;
  assign new_rec.seed        = in_item_i.seed;
  assign new_rec.create_info = in_item_i.create_info;
  assign new_rec.item_index  = in_item_i.item_index;

  // Examination of the slot under the walk pointer.
  assign last_idx  = count_q - 1'b1;
  assign pos_inc   = pos_q + 1'b1;
  assign count_dec = count_q - 1'b1;
  assign age       = req_q.now_ms - rd_a.stamp;
  assign expired   = age > expiry_q;
  assign key_match = (rd_a.seed == req_q.seed) && (rd_a.create_info == req_q.create_info)
                     && (rd_a.item_index == req_q.item_index);

  // Sequencer: start an operation, walk one slot per cycle, hand over a result.
  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    count_d   = count_q;
    mem_we    = 1'b0;
    mem_waddr = pos_q[AddrW-1:0];
    mem_wdata = rd_b;
    raddr_a   = pos_q[AddrW-1:0];
    raddr_b   = last_idx[AddrW-1:0];
    finish    = 1'b0;
    hit_d     = 1'b0;
    stored_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_item_i.func)
            dtr_pkg::FUNC_INSERT: begin
              finish = 1'b1;
              if (count_q < CapCnt) begin
                mem_we    = 1'b1;
                mem_waddr = count_q[AddrW-1:0];
                mem_wdata = new_rec;
                count_d   = count_q + 1'b1;
                stored_d  = 1'b1;
              end
            end
            dtr_pkg::FUNC_CHECK, dtr_pkg::FUNC_REMOVE: begin
              if (count_q == '0) begin
                finish = 1'b1;
              end else begin
                pos_d   = '0;
                raddr_a = '0;
                state_d = ST_WALK;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (expired) begin
          // Drop the stale record by moving the last one into its slot.
          count_d = count_dec;
          mem_we  = (pos_q != last_idx);
          if (pos_q >= count_dec) begin
            finish = 1'b1;
          end
        end else if (key_match) begin
          hit_d  = 1'b1;
          finish = 1'b1;
          if (req_q.func == dtr_pkg::FUNC_REMOVE) begin
            count_d = count_dec;
            mem_we  = (pos_q != last_idx);
          end
        end else begin
          pos_d = pos_inc;
          if (pos_inc >= count_q) begin
            finish = 1'b1;
          end
        end
        raddr_a = pos_d[AddrW-1:0];
        raddr_b = AddrW'(count_d - 1'b1);
      end
      ST_PUSH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    res_d.hit       = hit_d;
    res_d.stored    = stored_d;
    res_d.occupancy = 8'(count_d);
    if (finish) begin
      state_d = out_free ? ST_IDLE : ST_PUSH;
    end
  end

  // State, counters, request capture and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      count_q     <= '0;
      expiry_q    <= dtr_pkg::EXPIRY_RESET;
      req_q       <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        expiry_q <= cfg_wdata_i;
      end
      if (accept) begin
        req_q <= in_item_i;
      end
      if (finish && !out_free) begin
        res_q <= res_d;
      end
      if (finish && out_free) begin
        out_valid_q <= 1'b1;
        out_item_q  <= res_d;
      end else if ((state_q == ST_PUSH) && out_free) begin
        out_valid_q <= 1'b1;
        out_item_q  <= res_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  // The record count never exceeds the table size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("record count above capacity");

  // While walking, the pointer always addresses a held record.
  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (pos_q < count_q))
    else $error("walk pointer beyond held records");

  // A slot rewrite during the walk always comes with one record fewer.
  a_drop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_WALK) && mem_we) |=> (count_q == $past(count_dec)))
    else $error("slot rewrite without count decrement");

  // An accepted insert with room adds exactly one record.
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_item_i.func == dtr_pkg::FUNC_INSERT) && (count_q < CapCnt))
    |=> (count_q == $past(count_q) + 1'b1))
    else $error("insert did not add a record");

  // The waiting state is left only by handing the held result to the output.
  a_push_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_PUSH) && out_free) |=> (out_valid_q && (out_item_q == $past(res_q))))
    else $error("held result not delivered");
`endif

endmodule

[test/tb.sv]
// Self-checking testbench for the timed de-duplication record table.
// Streams check, insert, remove and unused-code items through the block and scores every result item.
// Depends on dtr_pkg and timed_dedup_record_table_unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 128;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 500;
  localparam int unsigned KEY_HISTORY = 48;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  dtr_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  dtr_pkg::out_item_t out_item;
  logic               cfg_we = 1'b0;
  logic [31:0]        cfg_wdata = '0;

  // Shadow copy of the record table and the expiry register.
  logic [31:0] rec_stamp [TABLE_DEPTH];
  logic [31:0] rec_seed  [TABLE_DEPTH];
  logic [15:0] rec_info  [TABLE_DEPTH];
  logic [15:0] rec_index [TABLE_DEPTH];
  int unsigned rec_count = 0;
  logic [31:0] expiry_limit = dtr_pkg::EXPIRY_RESET;

  // Items waiting to be offered, outcomes waiting to come back, recent keys.
  dtr_pkg::in_item_t  request_q[$];
  dtr_pkg::out_item_t outcome_q[$];
  dtr_pkg::in_item_t  key_hist[$];
  logic [31:0]        gen_clock = '0;

  bit                 idle_on = 1'b0;
  int unsigned        hold_asked = 0;
  int unsigned        hold_served = 0;
  int unsigned        hold_left = 0;
  int unsigned        gap_left = 0;
  int unsigned        stall_left = 0;
  int unsigned        mismatches = 0;
  dtr_pkg::out_item_t want;

  timed_dedup_record_table_unit #(.CAPACITY(TABLE_DEPTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Remove a record by moving the last one into its slot. Count must be nonzero.
  function automatic void evict_slot(int unsigned pos);
    rec_count--;
    if (pos != rec_count) begin
      rec_stamp[pos] = rec_stamp[rec_count];
      rec_seed[pos]  = rec_seed[rec_count];
      rec_info[pos]  = rec_info[rec_count];
      rec_index[pos] = rec_index[rec_count];
    end
  endfunction

  // Apply one item to the shadow table and return the result it must produce.
  function automatic dtr_pkg::out_item_t apply_table_op(dtr_pkg::in_item_t it);
    dtr_pkg::out_item_t res;
    int unsigned        pos;
    logic [31:0]        age;
    bit                 found;
    res = '0;
    pos = 0;
    found = 1'b0;
    case (it.func)
      dtr_pkg::FUNC_INSERT: begin
        if (rec_count < TABLE_DEPTH) begin
          rec_stamp[rec_count] = it.now_ms;
          rec_seed[rec_count]  = it.seed;
          rec_info[rec_count]  = it.create_info;
          rec_index[rec_count] = it.item_index;
          rec_count++;
          res.stored = 1'b1;
        end
      end
      dtr_pkg::FUNC_CHECK, dtr_pkg::FUNC_REMOVE: begin
        // Expired records are dropped in place and the slot is looked at again.
        while (!found && pos < rec_count) begin
          age = it.now_ms - rec_stamp[pos];
          if (age > expiry_limit) begin
            evict_slot(pos);
          end else if (rec_seed[pos] == it.seed && rec_info[pos] == it.create_info &&
                       rec_index[pos] == it.item_index) begin
            found = 1'b1;
            if (it.func == dtr_pkg::FUNC_REMOVE) evict_slot(pos);
          end else begin
            pos++;
          end
        end
        res.hit = found;
      end
      default: begin
      end
    endcase
    res.occupancy = rec_count[7:0];
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 100);
  endfunction

  function automatic void queue_item(dtr_pkg::in_item_t it);
    request_q.push_back(it);
    if (it.func == dtr_pkg::FUNC_INSERT) begin
      key_hist.push_back(it);
      if (key_hist.size() > KEY_HISTORY) void'(key_hist.pop_front());
    end
  endfunction

  function automatic void directed(logic [1:0] fn, logic [31:0] now, logic [31:0] sd,
                                   logic [15:0] ci, logic [15:0] ix);
    dtr_pkg::in_item_t it;
    it.func = fn;
    it.now_ms = now;
    it.seed = sd;
    it.create_info = ci;
    it.item_index = ix;
    queue_item(it);
  endfunction

  // Time mostly creeps forward by up to span; keys mostly repeat recent inserts,
  // sometimes with one bit flipped, sometimes fresh.
  function automatic dtr_pkg::in_item_t random_item(int unsigned span, int unsigned ins_pct);
    dtr_pkg::in_item_t it;
    dtr_pkg::in_item_t pick;
    int unsigned       r;
    r = $urandom_range(0, 99);
    if (r < 65) gen_clock += $urandom_range(0, span);
    else if (r >= 88 && r < 97) gen_clock += $urandom_range(0, 4 * span);
    else if (r >= 97) gen_clock = $urandom;
    it.now_ms = gen_clock;
    r = $urandom_range(0, 99);
    if (r < ins_pct) it.func = dtr_pkg::FUNC_INSERT;
    else if (r < 96) it.func = $urandom_range(0, 1) ? dtr_pkg::FUNC_REMOVE : dtr_pkg::FUNC_CHECK;
    else it.func = FUNC_UNUSED;
    if (key_hist.size() == 0 || $urandom_range(0, 99) < 25) begin
      it.seed = $urandom;
      it.create_info = 16'($urandom);
      it.item_index = 16'($urandom);
    end else begin
      pick = key_hist[$urandom_range(0, key_hist.size() - 1)];
      it.seed = pick.seed;
      it.create_info = pick.create_info;
      it.item_index = pick.item_index;
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: it.seed ^= 32'd1 << $urandom_range(0, 31);
          1: it.create_info ^= 16'd1 << $urandom_range(0, 15);
          default: it.item_index ^= 16'd1 << $urandom_range(0, 15);
        endcase
      end
    end
    return it;
  endfunction

  task automatic queue_random(int unsigned count, int unsigned span, int unsigned ins_pct);
    repeat (count) queue_item(random_item(span, ins_pct));
  endtask

  // Returns at a falling edge once no item is pending or in flight.
  task automatic wait_idle();
    while (request_q.size() != 0 || in_valid || outcome_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_expiry(logic [31:0] limit);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    expiry_limit = limit;
    @(negedge clk_i);
  endtask

  // Sender: predicts each accepted item, then offers the next, after a random gap while idle_on is set.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) outcome_q.push_back(apply_table_op(in_item));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          in_item <= request_q.pop_front();
          in_valid <= 1'b1;
          gap_left = idle_on ? draw_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random stalls while idle_on is set, plus a long hold-off whenever one is requested.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_served != hold_asked) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = idle_on ? draw_gap() : 0;
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: each accepted result item is scored against the oldest outcome.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (outcome_q.size() == 0) begin
        $error("result item with no outcome pending: %p", out_item);
        mismatches++;
      end else begin
        want = outcome_q.pop_front();
        if (out_item.hit !== want.hit) begin
          $error("hit mismatch: expected %0b, actual %0b", want.hit, out_item.hit);
          mismatches++;
        end
        if (out_item.stored !== want.stored) begin
          $error("stored mismatch: expected %0b, actual %0b", want.stored, out_item.stored);
          mismatches++;
        end
        if (out_item.occupancy !== want.occupancy) begin
          $error("occupancy mismatch: expected %0d, actual %0d",
                 want.occupancy, out_item.occupancy);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed items under the reset expiry limit.
    idle_on = 1'b1;
    directed(dtr_pkg::FUNC_CHECK,  32'd0,         32'd0,         16'h0000, 16'h0000);
    directed(dtr_pkg::FUNC_REMOVE, 32'd0,         32'd0,         16'h0000, 16'h0000);
    directed(FUNC_UNUSED,          32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    directed(dtr_pkg::FUNC_INSERT, 32'd1000,      32'h8000_0000, 16'h0000, 16'hFFFF);
    directed(dtr_pkg::FUNC_INSERT, 32'd1000,      32'h7FFF_FFFF, 16'hFFFF, 16'h0000);
    directed(dtr_pkg::FUNC_INSERT, 32'd1000,      32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    directed(dtr_pkg::FUNC_INSERT, 32'd1000,      32'd0,         16'h0000, 16'h0000);
    // Age exactly at the limit is still live; one differing key misses.
    directed(dtr_pkg::FUNC_CHECK,  32'd7000,      32'h8000_0000, 16'h0000, 16'hFFFF);
    directed(dtr_pkg::FUNC_CHECK,  32'd7000,      32'h8000_0000, 16'h0001, 16'hFFFF);
    directed(dtr_pkg::FUNC_REMOVE, 32'd7000,      32'h7FFF_FFFF, 16'hFFFF, 16'h0000);
    directed(dtr_pkg::FUNC_CHECK,  32'd7000,      32'h7FFF_FFFF, 16'hFFFF, 16'h0000);
    directed(FUNC_UNUSED,          32'd7000,      32'd0,         16'h0000, 16'h0000);
    // One past the limit: every record expires during the walk.
    directed(dtr_pkg::FUNC_CHECK,  32'd7001,      32'd0,         16'h0000, 16'h0000);
    // Time wrapping past zero, with a duplicate record.
    directed(dtr_pkg::FUNC_INSERT, 32'hFFFF_FF00, 32'h1234_5678, 16'h5A5A, 16'hA5A5);
    directed(dtr_pkg::FUNC_INSERT, 32'hFFFF_FF00, 32'h1234_5678, 16'h5A5A, 16'hA5A5);
    directed(dtr_pkg::FUNC_CHECK,  32'h0000_0100, 32'h1234_5678, 16'h5A5A, 16'hA5A5);
    directed(dtr_pkg::FUNC_REMOVE, 32'h0000_0100, 32'h1234_5678, 16'h5A5A, 16'hA5A5);
    directed(dtr_pkg::FUNC_REMOVE, 32'h0000_0100, 32'h1234_5678, 16'h5A5A, 16'hA5A5);
    // A stamp in the future looks very old and expires.
    directed(dtr_pkg::FUNC_INSERT, 32'd5000,      32'h0BAD_CAFE, 16'h0001, 16'h0002);
    directed(dtr_pkg::FUNC_CHECK,  32'd4000,      32'h0BAD_CAFE, 16'h0001, 16'h0002);
    // Removing slot 0 moves the last record into it.
    directed(dtr_pkg::FUNC_INSERT, 32'd4000,      32'd1,         16'h0010, 16'h0020);
    directed(dtr_pkg::FUNC_INSERT, 32'd4000,      32'd2,         16'h0010, 16'h0020);
    directed(dtr_pkg::FUNC_INSERT, 32'd4000,      32'd3,         16'h0010, 16'h0020);
    directed(dtr_pkg::FUNC_REMOVE, 32'd4000,      32'd1,         16'h0010, 16'h0020);
    directed(dtr_pkg::FUNC_CHECK,  32'd4000,      32'd3,         16'h0010, 16'h0020);
    gen_clock = 32'd4000;
    wait_idle();

    // Nothing expires: fill past capacity while the receiver holds off.
    set_expiry(32'hFFFF_FFFF);
    idle_on = 1'b0;
    queue_random(140, 5, 100);
    queue_random(60, 5, 15);
    hold_asked++;
    wait_idle();

    // Zero limit: only records stamped at the current time survive.
    set_expiry(32'd0);
    idle_on = 1'b1;
    queue_random(100, 2, 40);
    wait_idle();

    set_expiry(dtr_pkg::EXPIRY_RESET);
    queue_random(240, 400, 45);
    wait_idle();

    set_expiry(32'd100);
    idle_on = 1'b0;
    queue_random(200, 30, 45);
    wait_idle();

    set_expiry(32'd1);
    idle_on = 1'b1;
    queue_random(80, 1, 50);
    wait_idle();

    // Half the time range, with a second long hold-off.
    set_expiry(32'h7FFF_FFFF);
    queue_random(130, 1000, 40);
    hold_asked++;
    wait_idle();

    repeat (TABLE_DEPTH + 8) @(posedge clk_i);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/dtr_pkg.sv
hw/rtl/dtr_mem.sv
hw/rtl/timed_dedup_record_table_unit.sv
test/tb.sv
